// File: hdl/lzwd_pkg.sv
// Shared types, codes and constants of the LZW variable width decoder.
package lzwd_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int MIN_CODE_BITS     = 9;
  localparam int CODE_END          = 256;
  localparam int CODE_BUMP         = 257;
  localparam int CODE_FLUSH        = 258;
  localparam int CODE_FIRST_FREE   = 259;
  localparam int CNT_W             = 24;
  localparam int BUF_W             = 24;
  localparam int FILL_W            = 5;
  localparam logic [CNT_W-1:0] MAX_OUT_RESET = 24'd65536;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PULL    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_BYTE     = 3'd1,
    ST_NEED     = 3'd2,
    ST_END      = 3'd3,
    ST_ERROR    = 3'd4,
    ST_REFUSED  = 3'd5,
    ST_LIMIT    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_LITERAL = 2'd0,
    PH_RUN     = 2'd1,
    PH_ENDED   = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CC_LIT,
    CC_END,
    CC_FLUSH,
    CC_BUMP,
    CC_BAD,
    CC_KWK,
    CC_COPY
  } code_cls_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_CODE,
    RS_STACK
  } res_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_PULL,
    S_WALK,
    S_FIX,
    S_EMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     push;
    logic     restart;
    logic     pop;
    logic     take_code;
    logic     walk;
    logic     fix;
    logic     set_res;
    status_t  res_status;
    res_src_t res_src;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    phase_t    phase;
    logic      limit_hit;
    logic      stk_nonempty;
    logic      short_bits;
    logic      push_full;
    code_cls_t cls;
    logic      walk_root;
    logic      walk_ovf;
    logic      kwk;
  } dp_stat_t;

endpackage

// File: hdl/lzwd_in_if.sv
// Input channel: opcode and compressed byte with valid/ready.
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

// File: hdl/lzwd_out_if.sv
// Result channel: status and decoded byte with valid/ready.
interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  modport source (output valid, output status, output out_byte, input ready);
  modport sink (input valid, input status, input out_byte, output ready);
endinterface

// File: hdl/lzwd_datapath.sv
// Datapath: bit buffer, code unpacking, dictionary and stack memories, result registers.
module lzwd_datapath #(
  parameter int MaxCodeBits = lzwd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [23:0]           cfg_wr_data,
  input  logic [7:0]            in_data_byte,
  input  lzwd_pkg::ctrl_cmd_t   cmd,
  output lzwd_pkg::dp_stat_t    stat,
  output logic [2:0]            out_status,
  output logic [7:0]            out_byte
);
  import lzwd_pkg::*;

  localparam int AW    = MaxCodeBits;
  localparam int Depth = 1 << MaxCodeBits;
  localparam logic [AW-1:0] CodeEnd   = AW'(CODE_END);
  localparam logic [AW-1:0] CodeBump  = AW'(CODE_BUMP);
  localparam logic [AW-1:0] CodeFlush = AW'(CODE_FLUSH);
  localparam logic [AW:0]   FirstFree = (AW+1)'(CODE_FIRST_FREE);
  localparam logic [FILL_W-1:0] MinWidth = FILL_W'(MIN_CODE_BITS);
  localparam logic [FILL_W-1:0] MaxWidth = FILL_W'(MaxCodeBits);

  logic [CNT_W-1:0]  max_r;
  logic [BUF_W-1:0]  buf_r;
  logic [FILL_W-1:0] bfill_r;
  logic [FILL_W-1:0] cwidth_r;
  logic [AW:0]       nf_r;
  logic [AW-1:0]     prev_r;
  phase_t            phase_r;
  logic [CNT_W-1:0]  count_r;
  logic [AW:0]       sfill_r;
  logic [AW-1:0]     c_r;
  logic [AW:0]       n_r;
  logic              kwk_r;
  logic [AW-1:0]     code_r;
  logic [7:0]        first_r;
  logic [7:0]        byte_r;
  status_t           res_status_r;
  logic [7:0]        res_byte_r;
  logic [2:0]        out_status_r;
  logic [7:0]        out_byte_r;

  logic [AW+7:0] dict_mem [Depth];
  logic [7:0]    stack_mem [Depth];
  logic [AW+7:0] dict_rd_r;
  logic [7:0]    stack_rd_r;

  logic [FILL_W-1:0] shift_amt;
  logic [BUF_W-1:0]  shifted;
  logic [AW-1:0]     code;
  logic              code_lit;
  code_cls_t         cls;
  logic [AW-1:0]     e_parent;
  logic [7:0]        e_char;
  logic              root;
  logic              ovf;
  logic [AW-1:0]     dict_raddr;
  logic              dict_we;
  logic              stack_we;
  logic [AW-1:0]     stack_waddr;
  logic [7:0]        stack_wdata;
  logic [AW-1:0]     stack_raddr;
  logic [7:0]        res_byte_nxt;

  assign shift_amt = bfill_r - cwidth_r;
  assign shifted   = buf_r >> shift_amt;
  assign code      = shifted[AW-1:0] & ~({AW{1'b1}} << cwidth_r);
  assign code_lit  = (code[AW-1:8] == '0);
  assign e_parent  = dict_rd_r[AW+7:8];
  assign e_char    = dict_rd_r[7:0];
  assign root      = (c_r[AW-1:8] == '0);
  assign ovf       = n_r[AW];

  always_comb begin
    cls = CC_BAD;
    if (phase_r == PH_LITERAL) begin
      if (code_lit) begin
        cls = CC_LIT;
      end else if (code == CodeEnd) begin
        cls = CC_END;
      end
    end else begin
      priority if (code == CodeEnd) cls = CC_END;
      else if (code == CodeFlush) cls = CC_FLUSH;
      else if (code == CodeBump) cls = CC_BUMP;
      else if ({1'b0, code} > nf_r) cls = CC_BAD;
      else if ({1'b0, code} == nf_r) cls = CC_KWK;
      else cls = CC_COPY;
    end
  end

  assign stat.phase        = phase_r;
  assign stat.limit_hit    = (count_r >= max_r);
  assign stat.stk_nonempty = (sfill_r != '0);
  assign stat.short_bits   = (bfill_r < cwidth_r);
  assign stat.push_full    = (bfill_r > FILL_W'(16));
  assign stat.cls          = cls;
  assign stat.walk_root    = root;
  assign stat.walk_ovf     = ovf;
  assign stat.kwk          = kwk_r;

  // The chain walk follows parents straight out of the registered read data.
  assign dict_raddr  = cmd.walk ? e_parent : ((cls == CC_KWK) ? prev_r : code);
  assign dict_we     = cmd.walk && !ovf && root && !nf_r[AW];
  assign stack_we    = (cmd.walk && !ovf) || cmd.fix;
  assign stack_waddr = cmd.fix ? '0 : n_r[AW-1:0];
  assign stack_wdata = cmd.fix ? first_r : (root ? c_r[7:0] : e_char);
  assign stack_raddr = sfill_r[AW-1:0] - AW'(1);

  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[nf_r[AW-1:0]] <= {prev_r, c_r[7:0]};
    end
    dict_rd_r <= dict_mem[dict_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rd_r <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_OUT_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      buf_r    <= '0;
      bfill_r  <= '0;
      cwidth_r <= MinWidth;
      nf_r     <= FirstFree;
      prev_r   <= '0;
      phase_r  <= PH_LITERAL;
      count_r  <= '0;
      sfill_r  <= '0;
    end else begin
      if (cmd.push && !stat.push_full) begin
        buf_r   <= {buf_r[15:0], byte_r};
        bfill_r <= bfill_r + FILL_W'(8);
      end
      if (cmd.pop) begin
        sfill_r <= sfill_r - (AW+1)'(1);
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.take_code) begin
        bfill_r <= shift_amt;
        unique case (cls)
          CC_LIT: begin
            prev_r  <= code;
            phase_r <= PH_RUN;
            count_r <= count_r + CNT_W'(1);
          end
          CC_END:   phase_r <= PH_ENDED;
          CC_BAD:   phase_r <= PH_ERROR;
          CC_FLUSH: begin
            cwidth_r <= MinWidth;
            nf_r     <= FirstFree;
            phase_r  <= PH_LITERAL;
          end
          CC_BUMP: begin
            if (cwidth_r < MaxWidth) cwidth_r <= cwidth_r + FILL_W'(1);
          end
          CC_KWK, CC_COPY: begin
          end
          default: begin
          end
        endcase
      end
      if (cmd.walk) begin
        if (ovf) begin
          sfill_r <= '0;
          phase_r <= PH_ERROR;
        end else if (root) begin
          sfill_r <= n_r + (AW+1)'(1);
          prev_r  <= code_r;
          if (!nf_r[AW]) nf_r <= nf_r + (AW+1)'(1);
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.res_src)
      RS_CODE:  res_byte_nxt = code[7:0];
      RS_STACK: res_byte_nxt = stack_rd_r;
      default:  res_byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) byte_r <= in_data_byte;
    if (cmd.take_code) begin
      code_r <= code;
      kwk_r  <= (cls == CC_KWK);
      c_r    <= (cls == CC_KWK) ? prev_r : code;
      n_r    <= (cls == CC_KWK) ? (AW+1)'(1) : '0;
    end
    if (cmd.walk && !ovf) begin
      if (root) begin
        first_r <= c_r[7:0];
      end else begin
        c_r <= e_parent;
        n_r <= n_r + (AW+1)'(1);
      end
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_byte_r   <= res_byte_nxt;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_byte_r   <= res_byte_r;
    end
  end

  assign out_status = out_status_r;
  assign out_byte   = out_byte_r;

endmodule

// File: hdl/lzwd_ctrl.sv
// Controller: sequences push, restart and pull work and owns the result handshake.
module lzwd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  output logic                out_valid,
  input  logic                out_ready,
  input  lzwd_pkg::dp_stat_t  stat,
  output lzwd_pkg::ctrl_cmd_t cmd
);
  import lzwd_pkg::*;

  state_t  state_r, state_nxt;
  opcode_t op_r;
  logic    out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) op_r <= opcode_t'(in_opcode);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMD;
      S_CMD:  state_nxt = (op_r == OP_PULL) ? S_PULL : S_FIN;
      S_PULL: begin
        priority if (stat.phase == PH_ENDED || stat.phase == PH_ERROR) state_nxt = S_FIN;
        else if (stat.limit_hit) state_nxt = S_FIN;
        else if (stat.stk_nonempty) state_nxt = S_EMIT;
        else if (stat.short_bits) state_nxt = S_FIN;
        else if (stat.cls == CC_LIT) state_nxt = S_FIN;
        else if (stat.cls == CC_KWK || stat.cls == CC_COPY) state_nxt = S_WALK;
        else state_nxt = S_PULL;
      end
      S_WALK: begin
        if (stat.walk_ovf) state_nxt = S_PULL;
        else if (stat.walk_root) state_nxt = stat.kwk ? S_FIX : S_PULL;
      end
      S_FIX:  state_nxt = S_PULL;
      S_EMIT: state_nxt = S_FIN;
      S_FIN:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = ST_ACCEPTED;
    cmd.res_src    = RS_ZERO;
    unique case (state_r)
      S_IDLE: cmd.capture = in_valid;
      S_CMD: begin
        cmd.set_res = (op_r != OP_PULL);
        unique case (op_r)
          OP_PUSH: begin
            cmd.push       = 1'b1;
            cmd.res_status = stat.push_full ? ST_REFUSED : ST_ACCEPTED;
          end
          OP_RESTART: cmd.restart = 1'b1;
          OP_PULL, OP_NONE: begin
          end
          default: begin
          end
        endcase
      end
      S_PULL: begin
        priority if (stat.phase == PH_ENDED) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_END;
        end else if (stat.phase == PH_ERROR) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_ERROR;
        end else if (stat.limit_hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_LIMIT;
        end else if (stat.stk_nonempty) begin
          cmd.pop = 1'b1;
        end else if (stat.short_bits) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NEED;
        end else begin
          // A literal in the first-code phase is sent out at once.
          cmd.take_code = 1'b1;
          if (stat.cls == CC_LIT) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_BYTE;
            cmd.res_src    = RS_CODE;
          end
        end
      end
      S_WALK: cmd.walk = 1'b1;
      S_FIX:  cmd.fix  = 1'b1;
      S_EMIT: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_BYTE;
        cmd.res_src    = RS_STACK;
      end
      S_FIN: cmd.load_out = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hdl/lzw_variable_width_decoder_top.sv
// LZW variable width decoder: top level joining the controller and the datapath.
//
// Input words carry an opcode and a byte: push appends a compressed byte to the
// bit buffer, pull returns one decoded byte or a status, restart begins a new
// stream. Every input word yields exactly one result word (status, out_byte).
// The user writes the register max_output_bytes through cfg_wr_en/cfg_wr_data
// only while the decoder is idle; the block does not enforce this. It caps the number of decoded bytes per stream.
// A push, restart or unused opcode passes through the command and finish states.
// A pull that pops a pending byte passes through the pull, emit and finish
// states. A pull that ends in a status, or in the first literal of a stream,
// stays in the pull state while it consumes control codes and then finishes;
// a pull that decodes any other code also walks the dictionary chain, adds a
// fix step when the code is the next free code, and then pops and emits the
// first byte. The chain walk reads one dictionary entry per cycle from a memory
// with registered read data, which sets the pace.
// One word is in flight at a time; the next word is accepted once the result
// has moved to the output register, even while that result waits to be taken.
// A stalled receiver holds the result in the output register and stalls the
// next result only. Reset (rst_n low, synchronous) empties the decoder and sets
// the limit to 65536; the memories need no clearing.
module lzw_variable_width_decoder_top #(
  parameter int MaxCodeBits = lzwd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lzwd_in_if.sink     in_ch,
  lzwd_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  import lzwd_pkg::*;

  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_opcode;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_status;
  logic [7:0] out_byte;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;

  assign in_valid        = in_ch.valid;
  assign in_opcode       = in_ch.opcode;
  assign in_data_byte    = in_ch.data_byte;
  assign in_ch.ready     = in_ready;
  assign out_ready       = out_ch.ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_status;
  assign out_ch.out_byte = out_byte;

  lzwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lzwd_datapath #(.MaxCodeBits(MaxCodeBits)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_data_byte (in_data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_status   (out_status),
    .out_byte     (out_byte)
  );

endmodule

// File: hdl/lzwd_checker.sv
// Port-level checker for the LZW decoder, bound to the top level.
module lzwd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [7:0] out_byte
);
  import lzwd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 3'd7))
    else $error("undefined status code on the result channel");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_BYTE) |-> (out_byte == 8'd0))
    else $error("nonzero byte with a status that carries no byte");

endmodule

bind lzw_variable_width_decoder_top lzwd_checker u_lzwd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_byte   (out_byte)
);
